>>> rtl/mexp_pkg.sv
// Package for the modular exponentiation core: widths, microcode fields and control store.
package mexp_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(WORD_BITS + 1);
  localparam int PC_W      = 4;

  // datapath load operations
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_LDB  = 2'd1;  // load the base for its first reduction
  localparam logic [1:0] OP_MULR = 2'd2;  // result * base
  localparam logic [1:0] OP_SQ   = 2'd3;  // base * base

  // writeback targets
  localparam logic [1:0] WR_NONE = 2'd0;
  localparam logic [1:0] WR_BASE = 2'd1;
  localparam logic [1:0] WR_RES  = 2'd2;

  // jump conditions
  localparam logic [2:0] C_NEVER     = 3'd0;
  localparam logic [2:0] C_ALWAYS    = 3'd1;
  localparam logic [2:0] C_IN_ACC    = 3'd2;
  localparam logic [2:0] C_MOD_ZERO  = 3'd3;
  localparam logic [2:0] C_RED_LAST  = 3'd4;
  localparam logic [2:0] C_EXP0_CLR  = 3'd5;
  localparam logic [2:0] C_BITS_LEFT = 3'd6;
  localparam logic [2:0] C_OUT_TAKEN = 3'd7;

  // program steps
  localparam logic [PC_W-1:0] S_IDLE = 4'd0;
  localparam logic [PC_W-1:0] S_CHKZ = 4'd1;
  localparam logic [PC_W-1:0] S_LDB  = 4'd2;
  localparam logic [PC_W-1:0] S_REDB = 4'd3;
  localparam logic [PC_W-1:0] S_WRB  = 4'd4;
  localparam logic [PC_W-1:0] S_TST  = 4'd5;
  localparam logic [PC_W-1:0] S_MULR = 4'd6;
  localparam logic [PC_W-1:0] S_REDR = 4'd7;
  localparam logic [PC_W-1:0] S_WRR  = 4'd8;
  localparam logic [PC_W-1:0] S_SQ   = 4'd9;
  localparam logic [PC_W-1:0] S_REDS = 4'd10;
  localparam logic [PC_W-1:0] S_NEXT = 4'd11;
  localparam logic [PC_W-1:0] S_OUT  = 4'd12;

  typedef struct packed {
    logic [1:0]      op;
    logic            red;      // one restoring reduction step this cycle
    logic [1:0]      wr;
    logic            nxt_bit;  // shift exponent, count down bits
    logic            out;
    logic [2:0]      cond;
    logic            hold;     // stay on this step while cond is false
    logic [PC_W-1:0] target;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{op: OP_NONE, red: 1'b0, wr: WR_NONE, nxt_bit: 1'b0, out: 1'b0,
          cond: C_NEVER, hold: 1'b0, target: S_IDLE};
    case (pc)
      S_IDLE: begin w.cond = C_IN_ACC; w.hold = 1'b1; w.target = S_CHKZ; end
      S_CHKZ: begin w.cond = C_MOD_ZERO; w.target = S_OUT; end
      S_LDB:  w.op = OP_LDB;
      S_REDB: begin w.red = 1'b1; w.cond = C_RED_LAST; w.hold = 1'b1; w.target = S_WRB; end
      S_WRB:  w.wr = WR_BASE;
      S_TST:  begin w.cond = C_EXP0_CLR; w.target = S_SQ; end
      S_MULR: w.op = OP_MULR;
      S_REDR: begin w.red = 1'b1; w.cond = C_RED_LAST; w.hold = 1'b1; w.target = S_WRR; end
      S_WRR:  w.wr = WR_RES;
      S_SQ:   w.op = OP_SQ;
      S_REDS: begin w.red = 1'b1; w.cond = C_RED_LAST; w.hold = 1'b1; w.target = S_NEXT; end
      S_NEXT: begin
        w.wr = WR_BASE; w.nxt_bit = 1'b1; w.cond = C_BITS_LEFT; w.target = S_TST;
      end
      S_OUT:  begin w.out = 1'b1; w.cond = C_OUT_TAKEN; w.hold = 1'b1; w.target = S_IDLE; end
      default: begin w.cond = C_ALWAYS; w.target = S_IDLE; end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/modular_exponentiation_core.sv
// Modular exponentiation core: microcoded right-to-left square-and-multiply.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall  | in_base, in_exponent, in_modulus
//   out_    | output    | out_valid / out_stall| out_power_mod, out_zero_modulus
//
// One request at a time. Each modular product is a multiply step followed by a
// bit-serial restoring reduction that shifts in the low half of the product; the
// reduction loop sets the rate. A zero modulus skips the exponent loop and goes
// straight to the result. Synchronous active-low reset returns the sequencer to
// idle; in_stall is high whenever a request is in flight, and the result holds
// while out_stall is high.
module modular_exponentiation_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mexp_pkg::WORD_BITS-1:0] in_base,
  input  logic [mexp_pkg::WORD_BITS-1:0] in_exponent,
  input  logic [mexp_pkg::WORD_BITS-1:0] in_modulus,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mexp_pkg::WORD_BITS-1:0] out_power_mod,
  output logic                           out_zero_modulus
);

  localparam int W = mexp_pkg::WORD_BITS;

  logic [mexp_pkg::PC_W-1:0]  pc_r, pc_nxt;
  logic [W-1:0]               base_r, base_nxt;
  logic [W-1:0]               exp_r, exp_nxt;
  logic [W-1:0]               mod_r, mod_nxt;
  logic [W-1:0]               res_r, res_nxt;
  logic                       zero_r, zero_nxt;
  logic [W-1:0]               rem_r, rem_nxt;
  logic [W-1:0]               lo_r, lo_nxt;
  logic [mexp_pkg::CNT_W-1:0] rcnt_r, rcnt_nxt;
  logic [mexp_pkg::CNT_W-1:0] bcnt_r, bcnt_nxt;

  mexp_pkg::ctrl_t cw;
  logic            in_acc;
  logic            cond_hit;
  logic [2*W-1:0]  prod;
  logic [W-1:0]    mul_a;
  logic [W:0]      trial;
  logic [W:0]      diff;

  assign cw       = mexp_pkg::ucode(pc_r);
  assign in_stall = (pc_r != mexp_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign out_valid        = cw.out;
  assign out_power_mod    = res_r;
  assign out_zero_modulus = zero_r;

  // shared multiplier: result*base or base*base
  assign mul_a = (cw.op == mexp_pkg::OP_MULR) ? res_r : base_r;
  assign prod  = {{W{1'b0}}, mul_a} * {{W{1'b0}}, base_r};

  // one restoring step: shift the next product bit into the remainder
  assign trial = {rem_r, lo_r[W-1]};
  assign diff  = trial - {1'b0, mod_r};

  always_comb begin
    case (cw.cond)
      mexp_pkg::C_NEVER:     cond_hit = 1'b0;
      mexp_pkg::C_ALWAYS:    cond_hit = 1'b1;
      mexp_pkg::C_IN_ACC:    cond_hit = in_acc;
      mexp_pkg::C_MOD_ZERO:  cond_hit = zero_r;
      mexp_pkg::C_RED_LAST:  cond_hit = (rcnt_r == mexp_pkg::CNT_W'(1));
      mexp_pkg::C_EXP0_CLR:  cond_hit = !exp_r[0];
      mexp_pkg::C_BITS_LEFT: cond_hit = (bcnt_r != mexp_pkg::CNT_W'(1));
      mexp_pkg::C_OUT_TAKEN: cond_hit = !out_stall;
      default:               cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_hit) begin
      pc_nxt = cw.target;
    end else if (cw.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + mexp_pkg::PC_W'(1);
    end
  end

  always_comb begin
    base_nxt = base_r;
    exp_nxt  = exp_r;
    mod_nxt  = mod_r;
    res_nxt  = res_r;
    zero_nxt = zero_r;
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    rcnt_nxt = rcnt_r;
    bcnt_nxt = bcnt_r;

    if (in_acc) begin
      base_nxt = in_base;
      exp_nxt  = in_exponent;
      mod_nxt  = in_modulus;
      zero_nxt = (in_modulus == '0);
      // 1 mod m: zero for a modulus of zero or one
      res_nxt  = (in_modulus[W-1:1] == '0) ? '0 : W'(1);
      bcnt_nxt = mexp_pkg::CNT_W'(W);
    end

    case (cw.op)
      mexp_pkg::OP_LDB: begin
        rem_nxt  = '0;
        lo_nxt   = base_r;
        rcnt_nxt = mexp_pkg::CNT_W'(W);
      end
      mexp_pkg::OP_MULR, mexp_pkg::OP_SQ: begin
        // operands lie below m, so the high half already lies below m
        rem_nxt  = prod[2*W-1:W];
        lo_nxt   = prod[W-1:0];
        rcnt_nxt = mexp_pkg::CNT_W'(W);
      end
      default: ;
    endcase

    if (cw.red) begin
      rem_nxt  = diff[W] ? trial[W-1:0] : diff[W-1:0];
      lo_nxt   = {lo_r[W-2:0], 1'b0};
      rcnt_nxt = rcnt_r - mexp_pkg::CNT_W'(1);
    end

    case (cw.wr)
      mexp_pkg::WR_BASE: base_nxt = rem_r;
      mexp_pkg::WR_RES:  res_nxt  = rem_r;
      default: ;
    endcase

    if (cw.nxt_bit) begin
      exp_nxt  = {1'b0, exp_r[W-1:1]};
      bcnt_nxt = bcnt_r - mexp_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= mexp_pkg::S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    exp_r  <= exp_nxt;
    mod_r  <= mod_nxt;
    res_r  <= res_nxt;
    zero_r <= zero_nxt;
    rem_r  <= rem_nxt;
    lo_r   <= lo_nxt;
    rcnt_r <= rcnt_nxt;
    bcnt_r <= bcnt_nxt;
  end

  // remainder stays reduced throughout a reduction pass
  a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    cw.red |-> (rem_r < mod_r))
    else $error("remainder not below modulus during reduction");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_zero_modulus) |-> (out_power_mod < mod_r))
    else $error("result not reduced by modulus");

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_modulus) |-> (out_power_mod == '0))
    else $error("zero modulus with nonzero result");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while a result is pending");

endmodule

>>> sim/modular_exponentiation_core_tb.sv
// Self-checking testbench for the modular exponentiation core.
module modular_exponentiation_core_tb;

  localparam int WB            = mexp_pkg::WORD_BITS;
  localparam int QUIET_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [WB-1:0] power_mod;
    logic          zero_modulus;
  } power_result_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [WB-1:0] in_base = '0;
  logic [WB-1:0] in_exponent = '0;
  logic [WB-1:0] in_modulus = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [WB-1:0] out_power_mod;
  logic          out_zero_modulus;

  power_result_t expected_results[$];
  int            errors = 0;
  int            requests_sent = 0;
  int            zero_mod_sent = 0;
  int            results_checked = 0;
  int            quiet_cycles = 0;
  int            stall_left = 0;
  bit            idle_on = 1'b1;
  bit            stall_on = 1'b1;

  modular_exponentiation_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_base          (in_base),
    .in_exponent      (in_exponent),
    .in_modulus       (in_modulus),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_power_mod    (out_power_mod),
    .out_zero_modulus (out_zero_modulus)
  );

  always #6 clk = ~clk;

  // Right-to-left square-and-multiply at double width.
  function automatic power_result_t predict_power_mod(input logic [WB-1:0] b,
                                                      input logic [WB-1:0] e,
                                                      input logic [WB-1:0] m);
    power_result_t res;
    logic [63:0]   acc;
    logic [63:0]   sq;
    logic [63:0]   mm;
    mm = {32'd0, m};
    if (m == '0) begin
      res.power_mod = '0;
      res.zero_modulus = 1'b1;
      return res;
    end
    acc = 64'd1 % mm;
    sq  = {32'd0, b} % mm;
    for (int i = 0; i < WB; i++) begin
      if (e[i]) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
    end
    res.power_mod = acc[WB-1:0];
    res.zero_modulus = 1'b0;
    return res;
  endfunction

  function automatic logic [WB-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return {WB{1'b1}};
      2:       return $urandom_range(0, 15);
      3:       return {WB{1'b1}} >> $urandom_range(1, WB - 1);
      4:       return $urandom() >> $urandom_range(0, WB - 1);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [WB-1:0] pick_modulus();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return $urandom_range(1, 3);
      2:       return {WB{1'b1}} - $urandom_range(0, 15);
      3:       return {{(WB-1){1'b0}}, 1'b1} << $urandom_range(0, WB - 1);
      4:       return $urandom() >> $urandom_range(0, WB - 1);
      default: return $urandom();
    endcase
  endfunction

  // Drive one request and hold it until the core takes it.
  task automatic send_request(input logic [WB-1:0] b,
                              input logic [WB-1:0] e,
                              input logic [WB-1:0] m);
    int gap;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_base     <= b;
    in_exponent <= e;
    in_modulus  <= m;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_power_mod(b, e, m));
    requests_sent++;
    if (m == '0) zero_mod_sent++;
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic test_corner_operands();
    send_request(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(32'h0000_0005, 32'h0000_0000, 32'h0000_0007);
    send_request(32'h0000_0000, 32'h0000_0000, 32'h0000_000D);
    send_request(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
    send_request(32'h0000_3039, 32'h0000_02A6, 32'h0000_0001);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
    send_request(32'h0000_0000, 32'h0000_0005, 32'h0000_0061);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'h0000_0002, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'h0000_0003, 32'h0000_0001, 32'h0000_0005);
    send_request(32'h0000_0064, 32'h0000_0001, 32'h0000_0007);
    send_request(32'hFFFF_FFFF, 32'h0000_0002, 32'hFFFF_FFFB);
    send_request(32'h0000_0002, 32'h0000_000A, 32'h0000_03E8);
    send_request(32'h0000_0007, 32'h8000_0000, 32'h8000_0000);
    send_request(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002);
    send_request(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFF1);
    send_request(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5679);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0002);
  endtask

  task automatic test_random_operands();
    repeat (128) send_request(pick_operand(), pick_operand(), pick_modulus());
  endtask

  task automatic test_small_moduli();
    repeat (60) send_request(pick_operand(), pick_operand(), $urandom_range(0, 20));
  endtask

  task automatic test_back_to_back();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    repeat (60) send_request(pick_operand(), pick_operand(), pick_modulus());
  endtask

  // Compare each result with the oldest prediction; stall the output in bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: power_mod=%h zero_modulus=%b",
                   $time, out_power_mod, out_zero_modulus);
          errors++;
        end else begin
          power_result_t want;
          want = expected_results.pop_front();
          results_checked++;
          if (out_power_mod !== want.power_mod) begin
            $display("%0t: power_mod expected %h actual %h",
                     $time, want.power_mod, out_power_mod);
            errors++;
          end
          if (out_zero_modulus !== want.zero_modulus) begin
            $display("%0t: zero_modulus expected %b actual %b",
                     $time, want.zero_modulus, out_zero_modulus);
            errors++;
          end
        end
      end
      if (stall_on && stall_left == 0 && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 11);
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // End the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_operands();
    wait_results_drained();
    test_random_operands();
    wait_results_drained();
    test_small_moduli();
    // hold the sender until the core has returned everything
    wait_results_drained();
    test_back_to_back();
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d requests (%0d with a zero modulus), checked %0d results.",
             requests_sent, zero_mod_sent, results_checked);
    $display("Covered corner operands, random and small moduli, stall bursts, back-to-back.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_results.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> modular_exponentiation_core.f
rtl/mexp_pkg.sv
rtl/modular_exponentiation_core.sv
sim/modular_exponentiation_core_tb.sv
